>>> sv/u2j_pkg.sv
// shared types, constants and helper functions of the utf-8 to json escaper
// no dependencies; the front, fifo, back and top level files import this package
package u2j_pkg;

  // token queue between the front and the back
  localparam int Q_DEPTH = 4;
  localparam int QPtrW   = $clog2(Q_DEPTH);
  localparam int QCntW   = $clog2(Q_DEPTH + 1);

  // ascii characters used by the escapes
  localparam logic [6:0] CH_QUOTE  = 7'h22;
  localparam logic [6:0] CH_BSLASH = 7'h5c;
  localparam logic [6:0] CH_LOW_U  = 7'h75;

  // code point constants
  localparam logic [15:0] REPL_UNIT = 16'hfffd;
  localparam logic [20:0] CP_MAX    = 21'h10ffff;
  localparam logic [20:0] CP_SUR_LO = 21'h00d800;
  localparam logic [20:0] CP_SUR_HI = 21'h00dfff;
  localparam logic [20:0] CP_PLANE1 = 21'h010000;
  localparam logic [5:0]  HI_SUR    = 6'b110110;
  localparam logic [5:0]  LO_SUR    = 6'b110111;

  typedef enum logic [2:0] {
    TK_CHAR,   // one literal character
    TK_SHORT,  // backslash and one character
    TK_UNIT,   // \uxxxx of the low 16 value bits
    TK_PAIR,   // surrogate pair of a supplementary code point
    TK_CLOSE   // closing quote of the string
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e   kind;
    logic [20:0] value;
    logic        last;   // last token caused by its input item
  } tok_t;

  // number of continuation bytes a valid lead byte asks for, 0 otherwise
  function automatic logic [1:0] lead_need(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if (b >= 8'hc2 && b <= 8'hdf) n = 2'd1;
    else if (b >= 8'he0 && b <= 8'hef) n = 2'd2;
    else if (b >= 8'hf0 && b <= 8'hf4) n = 2'd3;
    return n;
  endfunction

  // true when a buffer starting with b and holding len bytes gives output
  // even without a string end (not a lead byte still waiting for its tail)
  function automatic logic emits_noend(input logic [7:0] b, input logic [2:0] len);
    logic [1:0] n;
    n = lead_need(b);
    return (len != 3'd0) && !((n != 2'd0) && (len < ({1'b0, n} + 3'd1)));
  endfunction

  function automatic logic [6:0] hex_char(input logic [3:0] n);
    logic [6:0] c;
    if (n < 4'd10) c = 7'h30 + {3'd0, n};
    else c = 7'h57 + {3'd0, n};
    return c;
  endfunction

  // characters one token expands to
  function automatic logic [3:0] tok_chars(input tok_kind_e k);
    logic [3:0] c;
    unique case (k)
      TK_CHAR:  c = 4'd1;
      TK_SHORT: c = 4'd2;
      TK_UNIT:  c = 4'd6;
      TK_PAIR:  c = 4'd12;
      TK_CLOSE: c = 4'd1;
      default:  c = 4'd1;
    endcase
    return c;
  endfunction

endpackage

>>> sv/u2j_if.sv
// valid/ready channel interfaces of the escaper: byte input and character output
// no dependencies
interface u2j_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       string_end;

  modport source (output valid, output data_byte, output byte_present,
                  output string_end, input ready);
  modport sink   (input valid, input data_byte, input byte_present,
                  input string_end, output ready);
endinterface

interface u2j_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_char;
  logic       run_last;
  logic       closing_quote;

  modport source (output valid, output out_char, output run_last,
                  output closing_quote, input ready);
  modport sink   (input valid, input out_char, input run_last,
                  input closing_quote, output ready);
endinterface

>>> sv/u2j_front.sv
// front of the escaper: accepts bytes, holds partial sequences, decodes them into tokens
// depends on u2j_pkg and u2j_in_if
module u2j_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  u2j_in_if.sink          in_i,
  input  logic            q_full_i,
  output logic            q_push_o,
  output u2j_pkg::tok_t   q_tok_o
);
  import u2j_pkg::*;

  logic       busy_q, busy_d;
  logic       in_string_q, in_string_d;
  logic       at_end_q, at_end_d;
  logic [2:0] wlen_q, wlen_d;
  logic [7:0] wbuf_q [4];
  logic [7:0] wbuf_d [4];

  logic [7:0]  b0, c1, c2, c3;
  logic [1:0]  need;
  logic        have_all, cont_ok, bad_seq, emit_here, push;
  logic [20:0] cp;
  logic [6:0]  esc;
  logic [2:0]  k, sidx;
  logic [7:0]  buf_sh [4];
  tok_t        step_tok, tok;

  function automatic logic [6:0] short_esc(input logic [7:0] b);
    logic [6:0] e;
    unique case (b)
      8'h22:   e = 7'h22;
      8'h5c:   e = 7'h5c;
      8'h08:   e = 7'h62;
      8'h0c:   e = 7'h66;
      8'h0a:   e = 7'h6e;
      8'h0d:   e = 7'h72;
      8'h09:   e = 7'h74;
      default: e = 7'h00;
    endcase
    return e;
  endfunction

  assign b0 = wbuf_q[0];
  assign c1 = wbuf_q[1];
  assign c2 = wbuf_q[2];
  assign c3 = wbuf_q[3];
  assign need = lead_need(b0);
  assign have_all = wlen_q >= ({1'b0, need} + 3'd1);
  assign esc = short_esc(b0);

  // code point of the sequence at the head of the buffer
  always_comb begin
    cp = '0;
    cont_ok = 1'b1;
    unique case (need)
      2'd1: begin
        cp = {10'd0, b0[4:0], c1[5:0]};
        cont_ok = (c1[7:6] == 2'b10);
      end
      2'd2: begin
        cp = {5'd0, b0[3:0], c1[5:0], c2[5:0]};
        cont_ok = (c1[7:6] == 2'b10) && (c2[7:6] == 2'b10);
      end
      2'd3: begin
        cp = {b0[2:0], c1[5:0], c2[5:0], c3[5:0]};
        cont_ok = (c1[7:6] == 2'b10) && (c2[7:6] == 2'b10) && (c3[7:6] == 2'b10);
      end
      default: begin
        cp = '0;
        cont_ok = 1'b1;
      end
    endcase
  end

  assign bad_seq = !cont_ok || (cp > CP_MAX) || (cp >= CP_SUR_LO && cp <= CP_SUR_HI)
                || (b0 == 8'he0 && c1 < 8'ha0) || (b0 == 8'hed && c1 >= 8'ha0)
                || (b0 == 8'hf0 && c1 < 8'h90) || (b0 == 8'hf4 && c1 >= 8'h90);

  assign emit_here = (wlen_q != 3'd0) && (at_end_q || emits_noend(b0, wlen_q));

  // token for the byte at the head and the bytes it consumes
  always_comb begin
    step_tok = '{kind: TK_UNIT, value: {5'd0, REPL_UNIT}, last: 1'b0};
    k = 3'd1;
    if (!b0[7]) begin
      if (esc != 7'h00) begin
        step_tok.kind  = TK_SHORT;
        step_tok.value = {14'd0, esc};
      end else if (b0 < 8'h20) begin
        step_tok.kind  = TK_UNIT;
        step_tok.value = {13'd0, b0};
      end else begin
        step_tok.kind  = TK_CHAR;
        step_tok.value = {14'd0, b0[6:0]};
      end
    end else if (need != 2'd0 && have_all && !bad_seq) begin
      step_tok.kind  = (cp >= CP_PLANE1) ? TK_PAIR : TK_UNIT;
      step_tok.value = cp;
      k = {1'b0, need} + 3'd1;
    end
  end

  // buffer after the consumed bytes leave
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sidx = 3'(i) + k;
      buf_sh[i] = (sidx < 3'd4) ? wbuf_q[sidx[1:0]] : 8'h00;
    end
  end

  always_comb begin
    busy_d      = busy_q;
    in_string_d = in_string_q;
    at_end_d    = at_end_q;
    wlen_d      = wlen_q;
    wbuf_d      = wbuf_q;
    push        = 1'b0;
    tok         = step_tok;
    if (!busy_q) begin
      if (in_i.valid && (in_i.byte_present || in_i.string_end)) begin
        busy_d   = 1'b1;
        at_end_d = in_i.string_end;
        if (in_i.byte_present) begin
          wbuf_d[wlen_q[1:0]] = in_i.data_byte;
          wlen_d = wlen_q + 3'd1;
        end
      end
    end else if (!in_string_q) begin
      // opening quote
      push       = 1'b1;
      tok.kind   = TK_CHAR;
      tok.value  = {14'd0, CH_QUOTE};
      tok.last   = !(at_end_q || emits_noend(b0, wlen_q));
      if (!q_full_i) begin
        in_string_d = 1'b1;
        if (tok.last) busy_d = 1'b0;
      end
    end else if (emit_here) begin
      push     = 1'b1;
      tok.last = !(at_end_q || emits_noend(buf_sh[0], wlen_q - k));
      if (!q_full_i) begin
        wbuf_d = buf_sh;
        wlen_d = wlen_q - k;
        if (tok.last) busy_d = 1'b0;
      end
    end else if (at_end_q) begin
      push      = 1'b1;
      tok.kind  = TK_CLOSE;
      tok.value = {14'd0, CH_QUOTE};
      tok.last  = 1'b1;
      if (!q_full_i) begin
        in_string_d = 1'b0;
        wlen_d      = 3'd0;
        busy_d      = 1'b0;
      end
    end else begin
      // partial sequence stays held for the next item
      busy_d = 1'b0;
    end
  end

  assign in_i.ready = !busy_q;
  assign q_push_o   = push && !q_full_i;
  assign q_tok_o    = tok;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      in_string_q <= 1'b0;
      at_end_q    <= 1'b0;
      wlen_q      <= 3'd0;
    end else begin
      busy_q      <= busy_d;
      in_string_q <= in_string_d;
      at_end_q    <= at_end_d;
      wlen_q      <= wlen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wbuf_q <= wbuf_d;
  end

endmodule

>>> sv/u2j_fifo.sv
// short token queue between the front and the back of the escaper
// depends on u2j_pkg
module u2j_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  u2j_pkg::tok_t tok_i,
  output logic          full_o,
  input  logic          pop_i,
  output u2j_pkg::tok_t tok_o,
  output logic          empty_o
);
  import u2j_pkg::*;

  tok_t             mem_q [Q_DEPTH];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(Q_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign tok_o   = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) wr_d = (wr_q == QPtrW'(Q_DEPTH - 1)) ? '0 : wr_q + QPtrW'(1);
    if (do_pop)  rd_d = (rd_q == QPtrW'(Q_DEPTH - 1)) ? '0 : rd_q + QPtrW'(1);
    if (do_push && !do_pop) cnt_d = cnt_q + QCntW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - QCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= tok_i;
  end

endmodule

>>> sv/u2j_back.sv
// back of the escaper: expands tokens into ascii characters behind an output register
// depends on u2j_pkg and u2j_out_if
module u2j_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  u2j_pkg::tok_t q_tok_i,
  input  logic          q_empty_i,
  output logic          q_pop_o,
  u2j_out_if.source     out_o
);
  import u2j_pkg::*;

  tok_t       cur_q, cur_d;
  logic       cur_valid_q, cur_valid_d;
  logic [3:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  logic [6:0] out_char_q, out_char_d;
  logic       run_last_q, run_last_d;
  logic       closing_q, closing_d;

  logic        can_load, last_char, pop;
  logic [6:0]  ch;
  logic [19:0] cpm;
  logic [15:0] unit;
  logic [3:0]  sub;

  assign cpm = 20'(cur_q.value - CP_PLANE1);
  assign sub = (idx_q >= 4'd6) ? idx_q - 4'd6 : idx_q;

  always_comb begin
    if (cur_q.kind == TK_PAIR) begin
      unit = (idx_q >= 4'd6) ? {LO_SUR, cpm[9:0]} : {HI_SUR, cpm[19:10]};
    end else begin
      unit = cur_q.value[15:0];
    end
  end

  // character at the current position of the token
  always_comb begin
    ch = CH_QUOTE;
    unique case (cur_q.kind) inside
      TK_CHAR:  ch = cur_q.value[6:0];
      TK_SHORT: ch = (idx_q == 4'd0) ? CH_BSLASH : cur_q.value[6:0];
      TK_UNIT, TK_PAIR: begin
        case (sub)
          4'd0:    ch = CH_BSLASH;
          4'd1:    ch = CH_LOW_U;
          4'd2:    ch = hex_char(unit[15:12]);
          4'd3:    ch = hex_char(unit[11:8]);
          4'd4:    ch = hex_char(unit[7:4]);
          default: ch = hex_char(unit[3:0]);
        endcase
      end
      TK_CLOSE: ch = CH_QUOTE;
      default:  ch = CH_QUOTE;
    endcase
  end

  assign can_load  = !out_valid_q || out_o.ready;
  assign last_char = (idx_q == tok_chars(cur_q.kind) - 4'd1);

  always_comb begin
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    run_last_d  = run_last_q;
    closing_d   = closing_q;
    pop         = 1'b0;
    if (can_load) begin
      out_valid_d = cur_valid_q;
      out_char_d  = ch;
      run_last_d  = cur_q.last && last_char;
      closing_d   = (cur_q.kind == TK_CLOSE);
    end
    if (!cur_valid_q || (can_load && last_char)) begin
      pop         = !q_empty_i;
      cur_valid_d = !q_empty_i;
      cur_d       = q_tok_i;
      idx_d       = 4'd0;
    end else if (can_load) begin
      idx_d = idx_q + 4'd1;
    end
  end

  assign q_pop_o             = pop;
  assign out_o.valid         = out_valid_q;
  assign out_o.out_char      = out_char_q;
  assign out_o.run_last      = run_last_q;
  assign out_o.closing_quote = closing_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
      idx_q       <= 4'd0;
    end else begin
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q      <= cur_d;
    out_char_q <= out_char_d;
    run_last_q <= run_last_d;
    closing_q  <= closing_d;
  end

endmodule

>>> sv/utf8_to_json_ascii_escaper.sv
// top level of the utf-8 to quoted pure-ascii json string escaper
// depends on u2j_pkg, u2j_if, u2j_front, u2j_fifo and u2j_back
// - in_i takes one item per transfer: data_byte with byte_present, and
//   string_end to close the string; an item with neither flag is dropped
// - out_o gives one ascii character per transfer; run_last marks the last
//   character caused by an input item, closing_quote marks the final quote
// - after a transfer the front pushes its tokens one at a time (a quote, a
//   literal or short escape, a \uxxxx unit, a surrogate pair), or only
//   holds the byte; in_i.ready is low meanwhile, and stays low longer
//   while the queue is full
// - the back gives one character per cycle while out_o.ready allows it, so
//   the rate is set by the slower of the two: the front for plain text,
//   the back for escapes
// - the first character of an item passes the front's held buffer, the token
//   queue, the back's current token and the output register to reach out_o
// - a stalled receiver fills the output register, the back's current token
//   and the four-entry token queue, and then holds the front and in_i.ready
// - reset clears the string state, the held byte count and the queue; the
//   next byte starts a new string with its opening quote
module utf8_to_json_ascii_escaper (
  input  logic       clk_i,
  input  logic       rst_ni,
  u2j_in_if.sink     in_i,
  u2j_out_if.source  out_o
);
  import u2j_pkg::*;

  // tokens from the decoding front into the queue
  tok_t push_tok;
  logic push;
  logic q_full;

  // tokens from the queue into the expanding back
  tok_t head_tok;
  logic q_empty;
  logic pop;

  u2j_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .q_full_i (q_full),
    .q_push_o (push),
    .q_tok_o  (push_tok)
  );

  u2j_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .tok_i   (push_tok),
    .full_o  (q_full),
    .pop_i   (pop),
    .tok_o   (head_tok),
    .empty_o (q_empty)
  );

  // back holds one token in work and registers each character
  u2j_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_tok_i   (head_tok),
    .q_empty_i (q_empty),
    .q_pop_o   (pop),
    .out_o     (out_o)
  );

endmodule
